// ===== hw/rtl/e2b_pkg.sv =====
// e2b_pkg: shared constants and helper functions for the epoch seconds to bcd date block
// used by the top level and the shared subtract unit; no dependencies
`timescale 1ns / 1ps

package e2b_pkg;

  // width of the shared subtract unit operands
  localparam int AluW = 18;

  // divisors used by the long division passes
  localparam logic [AluW-1:0] SECS_PER_DAY  = 18'd86400;
  localparam logic [AluW-1:0] DAYS_PER_WEEK = 18'd7;
  localparam logic [AluW-1:0] SECS_PER_HOUR = 18'd3600;
  localparam logic [AluW-1:0] SECS_PER_MIN  = 18'd60;

  // four consecutive years always hold exactly one leap year here
  localparam logic [AluW-1:0] DAYS_PER_QUAD = 18'd1461;
  localparam logic [AluW-1:0] DAYS_LEAP     = 18'd366;
  localparam logic [AluW-1:0] DAYS_COMMON   = 18'd365;

  // 1 january 1970 was a thursday
  localparam logic [15:0] WEEKDAY_OFFSET = 16'd4;

  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  localparam logic [11:0] FIRST_YEAR = 12'd2000;
  localparam logic [11:0] LAST_YEAR  = 12'd2099;

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;

  // cumulative days before a month (1..12) in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // packed bcd of a value below 100; tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== hw/rtl/e2b_alu.sv =====
// e2b_alu: shared subtract and compare unit of the date converter
// depends on e2b_pkg for the operand width
`timescale 1ns / 1ps

module e2b_alu (
  input  logic [e2b_pkg::AluW-1:0] a,
  input  logic [e2b_pkg::AluW-1:0] b,
  output logic [e2b_pkg::AluW-1:0] diff,
  output logic                     ge
);
  import e2b_pkg::*;

  logic [AluW:0] wide;

  // one subtractor; the borrow gives the compare
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[AluW-1:0];
  assign ge   = ~wide[AluW];

endmodule

// ===== hw/rtl/epoch_seconds_to_bcd_date_top.sv =====
// epoch_seconds_to_bcd_date_top: seconds since 1970 to bcd time, date and weekday
// from accept to out_strobe the work runs as four long divisions of
// 32, 16, 17 and 12 steps, a year walk (four years, then one year a step) and a
// month search, all through the one shared subtract unit (e2b_alu)
// one item at a time: busy stays high until the result; the receiver cannot stall
// synchronous active-low reset returns to idle with no result pending
`timescale 1ns / 1ps

module epoch_seconds_to_bcd_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [6:0]  out_sec_bcd,
  output logic [6:0]  out_min_bcd,
  output logic [5:0]  out_hour_bcd,
  output logic [2:0]  out_weekday,
  output logic [5:0]  out_day_bcd,
  output logic [4:0]  out_month_bcd,
  output logic [7:0]  out_year_bcd
);
  import e2b_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAYS,
    S_WDAY,
    S_HOURS,
    S_MINS,
    S_YEAR4,
    S_YEAR1,
    S_MONTH,
    S_MDAY
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] q_r, q_nxt;
  logic [16:0] r_r, r_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;

  logic        strobe_r, strobe_nxt;
  logic        valid_r, valid_nxt;
  logic [6:0]  sec_bcd_r, sec_bcd_nxt;
  logic [6:0]  min_bcd_r, min_bcd_nxt;
  logic [5:0]  hour_bcd_r, hour_bcd_nxt;
  logic [2:0]  wday_out_r, wday_out_nxt;
  logic [5:0]  day_bcd_r, day_bcd_nxt;
  logic [4:0]  month_bcd_r, month_bcd_nxt;
  logic [7:0]  year_bcd_r, year_bcd_nxt;

  logic [AluW-1:0] alu_a, alu_b, alu_diff;
  logic            alu_ge;
  logic [AluW-1:0] trial;
  logic [31:0]     q_step;
  logic [16:0]     r_step;
  logic            leap;
  logic [15:0]     days_wk;
  logic [4:0]      mday;
  logic [11:0]     year_off;
  logic            in_range;
  logic [7:0]      sec_b, min_b, hour_b, day_b, month_b, year_b;

  // shared subtract unit
  e2b_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  // restoring division step: shift in the next dividend bit
  assign trial  = {r_r, q_r[31]};
  assign q_step = {q_r[30:0], alu_ge};
  assign r_step = alu_ge ? alu_diff[16:0] : trial[16:0];

  assign leap     = (year_r[1:0] == 2'd0);
  assign days_wk  = q_step[15:0] + WEEKDAY_OFFSET;
  assign mday     = alu_diff[4:0] + 5'd1;
  assign year_off = year_r - FIRST_YEAR;
  assign in_range = (year_r >= FIRST_YEAR) && (year_r <= LAST_YEAR);

  // bcd of the fields ready at the final step
  assign sec_b   = to_bcd({1'b0, sec_r});
  assign min_b   = to_bcd({1'b0, min_r});
  assign hour_b  = to_bcd({2'b00, hour_r});
  assign day_b   = to_bcd({2'b00, mday});
  assign month_b = to_bcd({3'b000, month_r});
  assign year_b  = to_bcd(year_off[6:0]);

  // operand selection for the shared unit
  always_comb begin
    alu_a = trial;
    alu_b = SECS_PER_DAY;
    case (state_r)
      S_DAYS:  alu_b = SECS_PER_DAY;
      S_WDAY:  alu_b = DAYS_PER_WEEK;
      S_HOURS: alu_b = SECS_PER_HOUR;
      S_MINS:  alu_b = SECS_PER_MIN;
      S_YEAR4: begin
        alu_a = {2'b00, rem_r};
        alu_b = DAYS_PER_QUAD;
      end
      S_YEAR1: begin
        alu_a = {2'b00, rem_r};
        alu_b = leap ? DAYS_LEAP : DAYS_COMMON;
      end
      // days before the next month, plus the leap day once past february
      S_MONTH: begin
        alu_a = {2'b00, rem_r};
        alu_b = AluW'(days_before_month(month_r + 4'd1))
              + AluW'(leap && (month_r > MONTH_FIRST));
      end
      S_MDAY: begin
        alu_a = {2'b00, rem_r};
        alu_b = AluW'(days_before_month(month_r))
              + AluW'(leap && (month_r > 4'd2));
      end
      default: alu_a = trial;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    days_nxt      = days_r;
    tod_nxt       = tod_r;
    wday_nxt      = wday_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    rem_nxt       = rem_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    strobe_nxt    = 1'b0;
    valid_nxt     = valid_r;
    sec_bcd_nxt   = sec_bcd_r;
    min_bcd_nxt   = min_bcd_r;
    hour_bcd_nxt  = hour_bcd_r;
    wday_out_nxt  = wday_out_r;
    day_bcd_nxt   = day_bcd_r;
    month_bcd_nxt = month_bcd_r;
    year_bcd_nxt  = year_bcd_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          q_nxt     = in_epoch_seconds;
          r_nxt     = '0;
          cnt_nxt   = 5'd31;
          state_nxt = S_DAYS;
        end
      end
      // seconds / 86400, 32 steps
      S_DAYS: begin
        q_nxt   = q_step;
        r_nxt   = r_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          days_nxt  = q_step[15:0];
          tod_nxt   = r_step;
          q_nxt     = {days_wk, 16'd0};
          r_nxt     = '0;
          cnt_nxt   = 5'd15;
          state_nxt = S_WDAY;
        end
      end
      // (days + 4) mod 7, 16 steps
      S_WDAY: begin
        q_nxt   = q_step;
        r_nxt   = r_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          wday_nxt  = r_step[2:0];
          q_nxt     = {tod_r, 15'd0};
          r_nxt     = '0;
          cnt_nxt   = 5'd16;
          state_nxt = S_HOURS;
        end
      end
      // time of day / 3600, 17 steps
      S_HOURS: begin
        q_nxt   = q_step;
        r_nxt   = r_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          hour_nxt  = q_step[4:0];
          q_nxt     = {r_step[11:0], 20'd0};
          r_nxt     = '0;
          cnt_nxt   = 5'd11;
          state_nxt = S_MINS;
        end
      end
      // seconds of the hour / 60, 12 steps
      S_MINS: begin
        q_nxt   = q_step;
        r_nxt   = r_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          min_nxt   = q_step[5:0];
          sec_nxt   = r_step[5:0];
          rem_nxt   = days_r;
          year_nxt  = EPOCH_YEAR;
          state_nxt = S_YEAR4;
        end
      end
      // strip four years at a time
      S_YEAR4: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff[15:0];
          year_nxt = year_r + 12'd4;
        end else begin
          state_nxt = S_YEAR1;
        end
      end
      // then single years
      S_YEAR1: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff[15:0];
          year_nxt = year_r + 12'd1;
        end else begin
          month_nxt = MONTH_FIRST;
          state_nxt = S_MONTH;
        end
      end
      // month search over the cumulative table
      S_MONTH: begin
        if ((month_r != MONTH_LAST) && alu_ge) begin
          month_nxt = month_r + 4'd1;
        end else begin
          state_nxt = S_MDAY;
        end
      end
      // day of month and result
      S_MDAY: begin
        strobe_nxt = 1'b1;
        valid_nxt  = in_range;
        if (in_range) begin
          sec_bcd_nxt   = sec_b[6:0];
          min_bcd_nxt   = min_b[6:0];
          hour_bcd_nxt  = hour_b[5:0];
          wday_out_nxt  = wday_r;
          day_bcd_nxt   = day_b[5:0];
          month_bcd_nxt = month_b[4:0];
          year_bcd_nxt  = year_b;
        end else begin
          sec_bcd_nxt   = '0;
          min_bcd_nxt   = '0;
          hour_bcd_nxt  = '0;
          wday_out_nxt  = '0;
          day_bcd_nxt   = '0;
          month_bcd_nxt = '0;
          year_bcd_nxt  = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      strobe_r    <= strobe_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      cnt_r       <= cnt_nxt;
      days_r      <= days_nxt;
      tod_r       <= tod_nxt;
      wday_r      <= wday_nxt;
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      rem_r       <= rem_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      valid_r     <= valid_nxt;
      sec_bcd_r   <= sec_bcd_nxt;
      min_bcd_r   <= min_bcd_nxt;
      hour_bcd_r  <= hour_bcd_nxt;
      wday_out_r  <= wday_out_nxt;
      day_bcd_r   <= day_bcd_nxt;
      month_bcd_r <= month_bcd_nxt;
      year_bcd_r  <= year_bcd_nxt;
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = strobe_r;
  assign out_valid_res = valid_r;
  assign out_sec_bcd   = sec_bcd_r;
  assign out_min_bcd   = min_bcd_r;
  assign out_hour_bcd  = hour_bcd_r;
  assign out_weekday   = wday_out_r;
  assign out_day_bcd   = day_bcd_r;
  assign out_month_bcd = month_bcd_r;
  assign out_year_bcd  = year_bcd_r;

endmodule

// ===== hw/rtl/e2b_chk.sv =====
// e2b_chk: port-level checks on the date converter, bound to the top level
// depends on epoch_seconds_to_bcd_date_top; no package use
`timescale 1ns / 1ps

module e2b_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_valid_res,
  input logic [6:0] out_sec_bcd,
  input logic [6:0] out_min_bcd,
  input logic [5:0] out_hour_bcd,
  input logic [2:0] out_weekday,
  input logic [5:0] out_day_bcd,
  input logic [4:0] out_month_bcd,
  input logic [7:0] out_year_bcd
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a result only appears once the work on the item is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe while busy or without work");

  // one result per item: strobe is a single-cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  // out-of-range dates give all fields zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |->
      out_sec_bcd == 7'd0 && out_min_bcd == 7'd0 && out_hour_bcd == 6'd0 &&
      out_weekday == 3'd0 && out_day_bcd == 6'd0 && out_month_bcd == 5'd0 &&
      out_year_bcd == 8'd0)
    else $error("invalid result with nonzero fields");

  // a valid date has a real day and month and a weekday below seven
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid_res |->
      out_day_bcd != 6'd0 && out_month_bcd != 5'd0 && out_weekday != 3'd7)
    else $error("valid result with impossible date");

endmodule

bind epoch_seconds_to_bcd_date_top e2b_chk u_e2b_chk (.*);
